@@ sv/ldf_pkg.sv @@
// Package for the length-prefixed frame deframer.
// Holds event codes, controller states and default settings; no dependencies.
`timescale 1ns / 1ps

package ldf_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;

    localparam logic [15:0] IDLE_LIMIT_RESET = 16'd100;
    localparam logic [15:0] IDLE_TICKS_MAX   = 16'hFFFF;

    localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
    localparam logic [2:0] KIND_EMPTY     = 3'd1;
    localparam logic [2:0] KIND_CSUM_ERR  = 3'd2;
    localparam logic [2:0] KIND_OVERSIZE  = 3'd3;
    localparam logic [2:0] KIND_START_APP = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVENT,
        ST_RD_ADDR,
        ST_RD_WAIT
    } t_state;

endpackage

@@ sv/ldf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ldf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/length_prefixed_frame_deframer.sv @@
// Length-prefixed frame deframer: top level with frame controller and output register.
// Depends on ldf_pkg and ldf_ram (frame store).
//
// Takes one item at a time; input stalls while the controller is busy. A tick, a
// control word without event, a length byte or a mid-frame data byte causes no stall;
// an item that raises an event stalls input until it enters the output register. A
// good frame of length L is read back from the frame store once complete: its L-1
// payload bytes each go through ST_RD_ADDR, then ST_RD_WAIT for registered read data.
// A finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps

module length_prefixed_frame_deframer #(
    parameter int BUFFER_DEPTH = ldf_pkg::BUFFER_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [8:0]  i_link_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_kind,
    output logic [7:0]  o_payload_byte,
    output logic        o_last_of_frame,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [8:0] DEPTH_W = 9'(BUFFER_DEPTH);

    ldf_pkg::t_state r_state, n_state;

    logic [15:0] r_limit;
    logic [15:0] r_idle, n_idle;
    logic [7:0]  r_exp, n_exp;
    logic [7:0]  r_cnt, n_cnt;
    logic [7:0]  r_sum, n_sum;
    logic [2:0]  r_evt_kind, n_evt_kind;
    logic [7:0]  r_rd_last, n_rd_last;
    logic [7:0]  r_rd_idx;

    logic        r_out_valid;
    logic [2:0]  r_out_kind;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic        w_in_acc;
    logic        w_slot_free;
    logic        w_discard;
    logic [7:0]  w_cur_exp, w_cur_cnt, w_cur_sum;
    logic [7:0]  w_cnt1, w_sum1;
    logic        w_evt, w_readout, w_we;
    logic        w_re, w_out_load, w_rd_is_last;
    logic [7:0]  w_rdata;

    assign o_in_stall  = (r_state != ldf_pkg::ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    assign w_discard = (r_idle >= r_limit);
    assign w_cur_exp = w_discard ? 8'd0 : r_exp;
    assign w_cur_cnt = w_discard ? 8'd0 : r_cnt;
    assign w_cur_sum = w_discard ? 8'd0 : r_sum;
    assign w_cnt1    = w_cur_cnt + 8'd1;
    assign w_sum1    = w_cur_sum + i_link_word[7:0];
    assign w_rd_is_last = (r_rd_idx == r_rd_last);

    // item handling
    always_comb begin
        n_exp      = r_exp;
        n_cnt      = r_cnt;
        n_sum      = r_sum;
        n_idle     = r_idle;
        n_evt_kind = r_evt_kind;
        n_rd_last  = r_rd_last;
        w_evt      = 1'b0;
        w_readout  = 1'b0;
        w_we       = 1'b0;
        if (w_in_acc) begin
            if (i_opcode) begin
                if (r_idle != ldf_pkg::IDLE_TICKS_MAX) begin
                    n_idle = r_idle + 16'd1;
                end
            end else if (i_link_word[8]) begin
                n_exp  = 8'd0;
                n_cnt  = 8'd0;
                n_sum  = 8'd0;
                n_idle = 16'd0;
                if (i_link_word[7:0] != 8'd0) begin
                    w_evt      = 1'b1;
                    n_evt_kind = ldf_pkg::KIND_START_APP;
                end
            end else begin
                n_idle = 16'd0;
                if (w_cur_exp == 8'd0) begin
                    n_exp = i_link_word[7:0];
                    n_sum = i_link_word[7:0];
                    n_cnt = 8'd0;
                end else begin
                    w_we = ({1'b0, w_cur_cnt} < DEPTH_W);
                    if (w_cnt1 == w_cur_exp) begin
                        n_exp = 8'd0;
                        n_cnt = 8'd0;
                        n_sum = 8'd0;
                        if ({1'b0, w_cur_exp} > DEPTH_W) begin
                            w_evt      = 1'b1;
                            n_evt_kind = ldf_pkg::KIND_OVERSIZE;
                        end else if (w_sum1 != 8'd0) begin
                            w_evt      = 1'b1;
                            n_evt_kind = ldf_pkg::KIND_CSUM_ERR;
                        end else if (w_cur_exp == 8'd1) begin
                            w_evt      = 1'b1;
                            n_evt_kind = ldf_pkg::KIND_EMPTY;
                        end else begin
                            w_readout = 1'b1;
                            n_rd_last = w_cur_exp - 8'd2;
                        end
                    end else begin
                        n_exp = w_cur_exp;
                        n_cnt = w_cnt1;
                        n_sum = w_sum1;
                    end
                end
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ldf_pkg::ST_IDLE: begin
                if (w_evt) begin
                    n_state = ldf_pkg::ST_EVENT;
                end else if (w_readout) begin
                    n_state = ldf_pkg::ST_RD_ADDR;
                end
            end
            ldf_pkg::ST_EVENT: begin
                if (w_slot_free) begin
                    n_state = ldf_pkg::ST_IDLE;
                end
            end
            ldf_pkg::ST_RD_ADDR: begin
                n_state = ldf_pkg::ST_RD_WAIT;
            end
            ldf_pkg::ST_RD_WAIT: begin
                if (w_slot_free) begin
                    n_state = w_rd_is_last ? ldf_pkg::ST_IDLE : ldf_pkg::ST_RD_ADDR;
                end
            end
            default: begin
                n_state = ldf_pkg::ST_IDLE;
            end
        endcase
    end

    // controller outputs
    always_comb begin
        w_re       = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            ldf_pkg::ST_EVENT: begin
                w_out_load = w_slot_free;
            end
            ldf_pkg::ST_RD_ADDR: begin
                w_re = 1'b1;
            end
            ldf_pkg::ST_RD_WAIT: begin
                w_out_load = w_slot_free;
            end
            default: begin
                w_re       = 1'b0;
                w_out_load = 1'b0;
            end
        endcase
    end

    ldf_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_cur_cnt[AW-1:0]),
        .i_wdata (i_link_word[7:0]),
        .i_re    (w_re),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ldf_pkg::ST_IDLE;
            r_limit     <= ldf_pkg::IDLE_LIMIT_RESET;
            r_idle      <= 16'd0;
            r_exp       <= 8'd0;
            r_cnt       <= 8'd0;
            r_sum       <= 8'd0;
            r_rd_idx    <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idle  <= n_idle;
            r_exp   <= n_exp;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
            if (w_readout) begin
                r_rd_idx <= 8'd0;
            end else if (w_out_load && r_state == ldf_pkg::ST_RD_WAIT) begin
                r_rd_idx <= r_rd_idx + 8'd1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_evt_kind <= n_evt_kind;
        r_rd_last  <= n_rd_last;
        if (w_out_load) begin
            if (r_state == ldf_pkg::ST_RD_WAIT) begin
                r_out_kind <= ldf_pkg::KIND_PAYLOAD;
                r_out_byte <= w_rdata;
                r_out_last <= w_rd_is_last;
            end else begin
                r_out_kind <= r_evt_kind;
                r_out_byte <= 8'd0;
                r_out_last <= 1'b1;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_kind    = r_out_kind;
    assign o_payload_byte  = r_out_byte;
    assign o_last_of_frame = r_out_last;

    a_cnt_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp == 8'd0) ? (r_cnt == 8'd0) : (r_cnt < r_exp))
        else $error("received count out of range of frame length");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ldf_pkg::ST_RD_WAIT || r_state == ldf_pkg::ST_RD_ADDR)
        |-> ({1'b0, r_rd_idx} < DEPTH_W - 9'd1) && (r_rd_idx <= r_rd_last))
        else $error("readout index beyond frame payload");

    a_event_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) && (r_out_kind != ldf_pkg::KIND_PAYLOAD)
        |-> (r_out_byte == 8'd0) && r_out_last)
        else $error("event item carries payload or lacks last flag");

    a_start_app: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !i_opcode && i_link_word[8] && (i_link_word[7:0] != 8'd0)
        |=> (r_state == ldf_pkg::ST_EVENT) && (r_evt_kind == ldf_pkg::KIND_START_APP))
        else $error("start-application control word not reported");

    a_no_write_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ldf_pkg::ST_IDLE) |-> !w_we)
        else $error("frame store written during readout");

endmodule

@@ verif/ldf_event_checker.sv @@
// Checker for the length-prefixed frame deframer: watches the link, result and register
// channels, predicts the event stream and compares it field by field.
// Depends on ldf_pkg for event codes and the default store depth.
`timescale 1ns / 1ps

module ldf_event_checker #(
    parameter int STORE_DEPTH = ldf_pkg::BUFFER_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_opcode,
    input  logic [8:0]  i_link_word,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_event_kind,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_last_of_frame,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending_count,
    output int          o_checked_count
);

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
    } t_frame_event;

    t_frame_event expected_events[$];

    logic [15:0] idle_limit;
    logic [7:0]  frame_len;
    logic [7:0]  bytes_seen;
    logic [7:0]  byte_sum;
    logic [15:0] quiet_ticks;
    logic [7:0]  frame_bytes[STORE_DEPTH];

    initial begin
        o_fail_count    = 0;
        o_pending_count = 0;
        o_checked_count = 0;
    end

    function automatic void queue_event(logic [2:0] kind, logic [7:0] data, logic last);
        t_frame_event ev;
        ev.kind = kind;
        ev.data = data;
        ev.last = last;
        expected_events.push_back(ev);
    endfunction

    function automatic void drop_frame();
        frame_len  = 8'd0;
        bytes_seen = 8'd0;
        byte_sum   = 8'd0;
    endfunction

    task automatic absorb_link_item(input logic op, input logic [8:0] word);
        int i;
        if (op) begin
            if (quiet_ticks != ldf_pkg::IDLE_TICKS_MAX)
                quiet_ticks = quiet_ticks + 16'd1;
        end else if (word[8]) begin
            if (word[7:0] != 8'd0)
                queue_event(ldf_pkg::KIND_START_APP, 8'd0, 1'b1);
            drop_frame();
            quiet_ticks = 16'd0;
        end else begin
            if (quiet_ticks >= idle_limit)
                drop_frame();
            quiet_ticks = 16'd0;
            if (frame_len == 8'd0) begin
                frame_len  = word[7:0];
                byte_sum   = word[7:0];
                bytes_seen = 8'd0;
            end else begin
                if (int'(bytes_seen) < STORE_DEPTH)
                    frame_bytes[bytes_seen] = word[7:0];
                bytes_seen = bytes_seen + 8'd1;
                byte_sum   = byte_sum + word[7:0];
                if (bytes_seen == frame_len) begin
                    if (int'(frame_len) > STORE_DEPTH)
                        queue_event(ldf_pkg::KIND_OVERSIZE, 8'd0, 1'b1);
                    else if (byte_sum != 8'd0)
                        queue_event(ldf_pkg::KIND_CSUM_ERR, 8'd0, 1'b1);
                    else if (frame_len == 8'd1)
                        queue_event(ldf_pkg::KIND_EMPTY, 8'd0, 1'b1);
                    else
                        for (i = 0; i + 1 < int'(frame_len); i++)
                            queue_event(ldf_pkg::KIND_PAYLOAD, frame_bytes[i],
                                        (i + 2 == int'(frame_len)));
                    drop_frame();
                end
            end
        end
    endtask

    task automatic compare_event();
        t_frame_event want;
        o_checked_count++;
        if (expected_events.size() == 0) begin
            o_fail_count++;
            $display("%0t: unexpected item: expected none, got kind %0d byte %0d last %0d",
                     $time, i_event_kind, i_payload_byte, i_last_of_frame);
        end else begin
            want = expected_events.pop_front();
            if (i_event_kind !== want.kind) begin
                o_fail_count++;
                $display("%0t: event_kind mismatch: expected %0d, got %0d",
                         $time, want.kind, i_event_kind);
            end
            if (i_payload_byte !== want.data) begin
                o_fail_count++;
                $display("%0t: payload_byte mismatch: expected %0d, got %0d",
                         $time, want.data, i_payload_byte);
            end
            if (i_last_of_frame !== want.last) begin
                o_fail_count++;
                $display("%0t: last_of_frame mismatch: expected %0d, got %0d",
                         $time, want.last, i_last_of_frame);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_limit  = ldf_pkg::IDLE_LIMIT_RESET;
            quiet_ticks = 16'd0;
            drop_frame();
            expected_events.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                idle_limit = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                absorb_link_item(i_opcode, i_link_word);
            if (i_out_valid && !i_out_stall)
                compare_event();
        end
        o_pending_count <= expected_events.size();
    end

endmodule

@@ verif/testbench.sv @@
// Top of the deframer testbench: clock, reset, link and register stimulus, verdict.
// Depends on ldf_pkg, length_prefixed_frame_deframer and ldf_event_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int END_CYCLES     = 40;
    localparam int PHASE_ITEMS    = 100;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        i_opcode     = 1'b0;
    logic [8:0]  i_link_word  = 9'd0;
    logic        i_out_stall  = 1'b0;
    logic        i_cfg_valid  = 1'b0;
    logic [15:0] i_cfg_data   = 16'd0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_event_kind;
    logic [7:0]  o_payload_byte;
    logic        o_last_of_frame;
    logic        o_cfg_ready;

    int fail_count;
    int pending_count;
    int checked_count;

    int gap_pct    = 35;
    int stall_pct  = 65;
    int quiet_cycles = 0;
    int items_sent = 0;
    int ticks_sent = 0;
    int frames_sent = 0;
    int limits_written = 0;
    logic [15:0] idle_limit = ldf_pkg::IDLE_LIMIT_RESET;

    always #5 i_clk = ~i_clk;

    length_prefixed_frame_deframer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_link_word     (i_link_word),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_kind    (o_event_kind),
        .o_payload_byte  (o_payload_byte),
        .o_last_of_frame (o_last_of_frame),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    ldf_event_checker event_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_link_word     (i_link_word),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_event_kind    (o_event_kind),
        .i_payload_byte  (o_payload_byte),
        .i_last_of_frame (o_last_of_frame),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count),
        .o_checked_count (checked_count)
    );

    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, WATCHDOG_LIMIT, pending_count);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_item(input logic op, input logic [8:0] word);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_link_word <= word;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(1'b0, {1'b0, b});
    endtask

    task automatic send_ticks(input int count);
        repeat (count) begin
            send_item(1'b1, 9'($urandom_range(511)));
            ticks_sent++;
        end
    endtask

    function automatic int tick_span();
        return (idle_limit <= 16'd20) ? int'(idle_limit) + 1 : 3;
    endfunction

    task automatic maybe_ticks();
        if ($urandom_range(9) == 0)
            send_ticks($urandom_range(1, tick_span()));
    endtask

    // hold the link until every predicted result has come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
    endtask

    task automatic write_idle_limit(input logic [15:0] limit);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= limit;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        idle_limit = limit;
        limits_written++;
    endtask

    task automatic send_frame(input int len, input bit good);
        logic [7:0] sum;
        logic [7:0] b;
        int i;
        send_byte(8'(len));
        sum = 8'(len);
        for (i = 0; i < len - 1; i++) begin
            maybe_ticks();
            b = 8'($urandom_range(255));
            sum = sum + b;
            send_byte(b);
        end
        maybe_ticks();
        send_byte(good ? 8'(8'd0 - sum) : 8'($urandom_range(255)));
        frames_sent++;
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(1, 12);
        else if (r < 93)
            return $urandom_range(13, ldf_pkg::BUFFER_DEPTH_DEF);
        else
            return $urandom_range(ldf_pkg::BUFFER_DEPTH_DEF + 1, 96);
    endfunction

    task automatic run_random(input int count);
        int stop_at;
        int r;
        int len;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 65) begin
                send_frame(pick_length(), $urandom_range(4) != 0);
            end else if (r < 75) begin
                // abandon a frame part way, then either abort or go silent
                len = $urandom_range(2, 12);
                send_byte(8'(len));
                repeat ($urandom_range(1, len - 1))
                    send_byte(8'($urandom_range(255)));
                if ($urandom_range(1))
                    send_item(1'b0, 9'($urandom_range(256, 511)));
                else
                    send_ticks(tick_span());
            end else if (r < 83) begin
                send_item(1'b0, 9'($urandom_range(256, 511)));
            end else if (r < 91) begin
                send_ticks($urandom_range(1, tick_span()));
            end else begin
                send_byte(8'd0);
            end
            if ($urandom_range(24) == 0)
                drain_results();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed checks at the reset limit
        send_item(1'b0, 9'h100);
        send_item(1'b0, 9'h1FF);
        send_byte(8'd0);
        send_byte(8'd1);
        send_byte(8'hFF);
        send_byte(8'd3);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFE);
        send_byte(8'd2);
        send_byte(8'h55);
        send_byte(8'h00);
        send_byte(8'd4);
        send_byte(8'd1);
        send_item(1'b0, 9'h180);
        send_byte(8'd2);
        send_ticks(3);
        send_byte(8'h80);
        send_byte(8'h7E);

        // smallest limit: one tick of silence drops the partial frame
        write_idle_limit(16'd1);
        send_byte(8'd4);
        send_byte(8'd7);
        send_ticks(1);
        send_byte(8'd2);
        send_byte(8'h10);
        send_byte(8'hEE);

        write_idle_limit(16'd3);
        run_random(PHASE_ITEMS);

        write_idle_limit(16'd20);
        gap_pct   = 65;
        stall_pct = 35;
        run_random(PHASE_ITEMS);

        // largest limit: short silence keeps the partial frame
        write_idle_limit(16'hFFFF);
        gap_pct   = 0;
        stall_pct = 0;
        send_byte(8'd5);
        send_byte(8'd9);
        send_ticks(3);
        send_byte(8'd1);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hF2);
        run_random(PHASE_ITEMS);

        drain_results();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("Sent %0d link items (%0d ticks), %0d frames, under %0d idle limits;",
                 items_sent, ticks_sent, frames_sent, limits_written + 1);
        $display("checked %0d result items with sender gaps and receiver stalls.",
                 checked_count);
        if (fail_count == 0 && pending_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
